>>> hw/rtl/srht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srht_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int COORD_BITS  = 16;

	localparam int IDX_BITS   = $clog2(MAX_ENTRIES);
	localparam int CNT_BITS   = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_BITS = 4 * COORD_BITS;
	localparam int AREA_BITS  = 2 * COORD_BITS;

	localparam int FIELD_BITS     = 16;
	localparam int READ_IDX_BITS  = 6;
	localparam int CMP_BITS       = (CNT_BITS > READ_IDX_BITS) ? CNT_BITS : READ_IDX_BITS;
	localparam int IN_DATA_BITS   = 104;
	localparam int OUT_DATA_BITS  = 80;

	localparam int OFS_RECT_X   = 0;
	localparam int OFS_RECT_Y   = 16;
	localparam int OFS_RECT_W   = 32;
	localparam int OFS_RECT_H   = 48;
	localparam int OFS_POINT_X  = 64;
	localparam int OFS_POINT_Y  = 80;
	localparam int OFS_READ_IDX = 96;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_ERASE  = 2'd1,
		FN_SELECT = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_ERASE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/srht_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module srht_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/smallest_rect_hit_test_table.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  tdata                                                   tuser
// s_axis   in   rect_x, rect_y, rect_w, rect_h, point_x, point_y, idx  func
// m_axis   out  changed, selected_index, entry_count, overflow, x..h   -
//
// erase and select on an empty table skip the table walk
// erase and select step one table entry per cycle through the single ram
// a new transaction is taken while the previous result waits on m_axis
// reset clears count and selection; table contents stay undefined
// m_tready low holds the result and stalls only the next completion

module smallest_rect_hit_test_table
	import srht_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// rect_x, rect_y, rect_w, rect_h, point_x, point_y, read_index, zero pad
	input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
	// func
	input  wire logic [1:0]               s_tuser,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// changed, selected_index, entry_count, overflow, out_x, out_y, out_w, out_h, zero pad
	output logic      [OUT_DATA_BITS-1:0] m_tdata
);

	state_t state_q, state_d;
	func_t  fn;

	logic [CNT_BITS-1:0]   count_q;
	logic [IDX_BITS-1:0]   sel_q;
	logic [CNT_BITS-1:0]   ptr_q;
	logic                  found_q;
	logic                  out_valid_q;
	logic                  v_s1, v_s2, wv_s1;
	logic [IDX_BITS-1:0]   idx_s1, idx_s2, wa_s1;
	logic                  hold_s2;
	logic [AREA_BITS-1:0]  area_s2, best_area_q;
	logic [IDX_BITS-1:0]   best_q;
	logic [COORD_BITS-1:0] px_q, py_q;
	logic                  rd_ok_q;
	logic [ENTRY_BITS-1:0] rd_q;
	logic                  changed_q, ovf_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;

	logic                  in_acc, full, out_free, issue;
	logic                  erase_done, scan_done;
	logic                  ram_we;
	logic [IDX_BITS-1:0]   ram_waddr, ram_raddr;
	logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata, new_entry;
	logic [COORD_BITS-1:0] ex, ey, ew, eh;
	logic                  hold_c;
	logic [AREA_BITS-1:0]  area_c;

	assign fn         = func_t'(s_tuser);
	assign s_tready   = (state_q == ST_IDLE);
	assign in_acc     = s_tvalid && s_tready;
	assign full       = (count_q >= CNT_BITS'(MAX_ENTRIES));
	assign out_free   = !out_valid_q || m_tready;
	assign erase_done = (ptr_q >= count_q) && !wv_s1;
	assign scan_done  = (ptr_q >= count_q) && !v_s1 && !v_s2;

	assign new_entry = {s_tdata[OFS_RECT_H +: COORD_BITS], s_tdata[OFS_RECT_W +: COORD_BITS],
		s_tdata[OFS_RECT_Y +: COORD_BITS], s_tdata[OFS_RECT_X +: COORD_BITS]};

	assign ex = ram_rdata[0 +: COORD_BITS];
	assign ey = ram_rdata[COORD_BITS +: COORD_BITS];
	assign ew = ram_rdata[2*COORD_BITS +: COORD_BITS];
	assign eh = ram_rdata[3*COORD_BITS +: COORD_BITS];

	assign hold_c = (ex <= px_q) &&
		((COORD_BITS+1)'(px_q) < ((COORD_BITS+1)'(ex) + (COORD_BITS+1)'(ew))) &&
		(ey <= py_q) &&
		((COORD_BITS+1)'(py_q) < ((COORD_BITS+1)'(ey) + (COORD_BITS+1)'(eh)));
	assign area_c = AREA_BITS'(ew) * AREA_BITS'(eh);

	srht_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (fn)
						FN_ADD:    state_d = ST_DONE;
						FN_ERASE:  state_d = (count_q == '0) ? ST_DONE : ST_ERASE;
						FN_SELECT: state_d = (count_q == '0) ? ST_DONE : ST_SCAN;
						FN_READ:   state_d = ST_READ;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_READ:  state_d = ST_DONE;
			ST_ERASE: if (erase_done) state_d = ST_DONE;
			ST_SCAN:  if (scan_done) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ram control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_s1;
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q[IDX_BITS-1:0];
		issue     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && fn == FN_ADD && !full) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[IDX_BITS-1:0];
					ram_wdata = new_entry;
				end
				if (fn == FN_READ) begin
					ram_raddr = IDX_BITS'(s_tdata[OFS_READ_IDX +: READ_IDX_BITS]);
				end
			end
			ST_ERASE: begin
				ram_we = wv_s1;
				issue  = (ptr_q < count_q);
			end
			ST_SCAN: issue = (ptr_q < count_q);
			default: issue = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sel_q       <= '0;
			ptr_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			wv_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_SCAN) && issue;
			v_s2    <= v_s1;
			wv_s1   <= (state_q == ST_ERASE) && issue;
			if (issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						found_q <= 1'b0;
						case (fn)
							FN_ADD: begin
								if (!full) begin
									sel_q   <= count_q[IDX_BITS-1:0];
									count_q <= count_q + 1'b1;
								end
							end
							FN_ERASE:  ptr_q <= CNT_BITS'(sel_q) + 1'b1;
							FN_SELECT: ptr_q <= '0;
							default:   ptr_q <= ptr_q;
						endcase
					end
				end
				ST_ERASE: begin
					if (erase_done) begin
						count_q <= count_q - 1'b1;
						sel_q   <= (count_q > CNT_BITS'(1)) ?
							IDX_BITS'(count_q - CNT_BITS'(2)) : '0;
					end
				end
				ST_SCAN: begin
					if (v_s2 && hold_s2 && (!found_q || area_s2 < best_area_q)) begin
						found_q <= 1'b1;
					end
					if (scan_done && found_q && best_q != sel_q) begin
						sel_q <= best_q;
					end
				end
				default: found_q <= found_q;
			endcase
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= ptr_q[IDX_BITS-1:0];
		idx_s2  <= idx_s1;
		wa_s1   <= IDX_BITS'(ptr_q - 1'b1);
		hold_s2 <= hold_c;
		area_s2 <= area_c;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					changed_q <= 1'b0;
					ovf_q     <= (fn == FN_ADD) && full;
					rd_q      <= '0;
					px_q      <= s_tdata[OFS_POINT_X +: COORD_BITS];
					py_q      <= s_tdata[OFS_POINT_Y +: COORD_BITS];
					rd_ok_q   <= CMP_BITS'(s_tdata[OFS_READ_IDX +: READ_IDX_BITS]) <
						CMP_BITS'(count_q);
				end
			end
			ST_READ: rd_q <= rd_ok_q ? ram_rdata : '0;
			ST_SCAN: begin
				if (v_s2 && hold_s2 && (!found_q || area_s2 < best_area_q)) begin
					best_area_q <= area_s2;
					best_q      <= idx_s2;
				end
				if (scan_done && found_q && best_q != sel_q) begin
					changed_q <= 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_data_q <= {1'b0,
						FIELD_BITS'(rd_q[3*COORD_BITS +: COORD_BITS]),
						FIELD_BITS'(rd_q[2*COORD_BITS +: COORD_BITS]),
						FIELD_BITS'(rd_q[COORD_BITS +: COORD_BITS]),
						FIELD_BITS'(rd_q[0 +: COORD_BITS]),
						ovf_q, 7'(count_q), 6'(sel_q), changed_q};
				end
			end
			default: rd_q <= rd_q;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_ENTRIES))
		else $error("entry count beyond table depth");

	a_sel_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (CNT_BITS'(sel_q) < count_q))
		else $error("selection outside stored entries");

	a_sel_zero_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (sel_q == '0))
		else $error("selection nonzero on empty table");

	a_shift_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		wv_s1 |-> (CNT_BITS'(wa_s1) < ptr_q))
		else $error("erase write overtakes read pointer");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !ram_we)
		else $error("table written during select scan");

endmodule

`default_nettype wire
